FILE: rtl/bva_pkg.sv
// ----------------------------------------------------------------------------
// bva_pkg
// Shared types and constants for the battery voltage averager.
// ----------------------------------------------------------------------------
package bva_pkg;

    // averaging depth: 2^AVG_LOG2 sample pairs per measurement
    localparam int AVG_LOG2 = 4;
    localparam int AVG_N    = 1 << AVG_LOG2;

    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = SAMPLE_W + AVG_LOG2;
    localparam int CNT_W    = AVG_LOG2 + 1;

    // arithmetic widths
    localparam int MCAND_W  = 13;                    // 6600 and (6600*vbat)>>12
    localparam int CAL_W    = 12;
    localparam int PROD_W   = MCAND_W + SAMPLE_W;    // 25-bit products
    localparam int STEP_W   = 5;                     // iteration counter
    localparam int CACHE_W  = 15;                    // 0..32767
    localparam int MV_W     = 16;

    localparam logic [MCAND_W-1:0] FULL_SCALE_X2 = 13'd6600;
    localparam logic [CACHE_W-1:0] MV_MAX        = 15'h7FFF;
    localparam logic [CACHE_W-1:0] LOW_LIMIT_MV  = 15'd100;

    // APB register map
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_OFFSET   = 2'd0;
    localparam logic [1:0] REG_CAL      = 2'd1;
    localparam logic [1:0] REG_INTERVAL = 2'd2;

    localparam logic [MV_W-1:0]  OFFSET_RST   = 16'd0;
    localparam logic [CAL_W-1:0] CAL_RST      = 12'd1530;
    localparam logic [31:0]      INTERVAL_RST = 32'd5000;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_SAMPLE = 2'd1,
        MODE_READ   = 2'd2
    } t_mode;

    typedef struct packed {
        logic busy;
        logic done;
    } t_arith_status;

endpackage

FILE: rtl/bva_arith.sv
// ----------------------------------------------------------------------------
// bva_arith
// Bit-serial millivolt computation: ((6600*vbat)>>12)*cal / vref, saturated.
// ----------------------------------------------------------------------------
module bva_arith
    import bva_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SAMPLE_W-1:0] i_ref_avg,
    input  logic [SAMPLE_W-1:0] i_bat_avg,
    input  logic [CAL_W-1:0]    i_cal,
    output t_arith_status       o_status,
    output logic [CACHE_W-1:0]  o_mv
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_BAT,
        ST_MUL_CAL,
        ST_DIV,
        ST_DONE
    } t_state;

    localparam logic [STEP_W-1:0] MUL_TOP = STEP_W'(SAMPLE_W - 1);
    localparam logic [STEP_W-1:0] DIV_TOP = STEP_W'(PROD_W - 1);

    t_state               r_state, n_state;
    logic [STEP_W-1:0]    r_cnt, n_cnt;
    logic [PROD_W-1:0]    r_acc, n_acc;       // product, then dividend/quotient
    logic [MCAND_W-1:0]   r_mcand, n_mcand;
    logic [SAMPLE_W-1:0]  r_mplier, n_mplier;
    logic [SAMPLE_W-1:0]  r_div, n_div;
    logic [SAMPLE_W-1:0]  r_rem, n_rem;
    logic [CAL_W-1:0]     r_cal, n_cal;
    logic [CACHE_W-1:0]   r_mv, n_mv;

    logic [PROD_W-1:0]    mul_sum;
    logic [SAMPLE_W:0]    trial;
    logic [SAMPLE_W:0]    diff;
    logic                 ge;
    logic [PROD_W-1:0]    quo_next;

    // MSB-first shift-add, one multiplier bit per cycle
    assign mul_sum = {r_acc[PROD_W-2:0], 1'b0}
                   + (r_mplier[SAMPLE_W-1] ? PROD_W'(r_mcand) : '0);

    // restoring division, one quotient bit per cycle
    assign trial    = {r_rem, r_acc[PROD_W-1]};
    assign ge       = trial >= {1'b0, r_div};
    assign diff     = trial - {1'b0, r_div};
    assign quo_next = {r_acc[PROD_W-2:0], ge};

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_div    = r_div;
        n_rem    = r_rem;
        n_cal    = r_cal;
        n_mv     = r_mv;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state  = ST_MUL_BAT;
                    n_cnt    = MUL_TOP;
                    n_acc    = '0;
                    n_mcand  = FULL_SCALE_X2;
                    n_mplier = i_bat_avg;
                    n_div    = i_ref_avg;
                    n_cal    = i_cal;
                end
            end
            ST_MUL_BAT: begin
                n_acc    = mul_sum;
                n_mplier = {r_mplier[SAMPLE_W-2:0], 1'b0};
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    // >>12 of the first product becomes the next multiplicand
                    n_state  = ST_MUL_CAL;
                    n_cnt    = MUL_TOP;
                    n_acc    = '0;
                    n_mcand  = mul_sum[PROD_W-1:PROD_W-MCAND_W];
                    n_mplier = r_cal;
                end
            end
            ST_MUL_CAL: begin
                n_acc    = mul_sum;
                n_mplier = {r_mplier[SAMPLE_W-2:0], 1'b0};
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_DIV;
                    n_cnt   = DIV_TOP;
                    n_rem   = '0;
                end
            end
            ST_DIV: begin
                // zero divisor yields an all-ones quotient, which saturates
                n_acc = quo_next;
                n_rem = ge ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                    n_mv    = (|quo_next[PROD_W-1:CACHE_W]) ? MV_MAX
                                                            : quo_next[CACHE_W-1:0];
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_div    <= n_div;
        r_rem    <= n_rem;
        r_cal    <= n_cal;
        r_mv     <= n_mv;
    end

    assign o_status.busy = (r_state != ST_IDLE);
    assign o_status.done = (r_state == ST_DONE);
    assign o_mv          = r_mv;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == ST_IDLE)
        else $error("start while arithmetic unit busy");

    a_start_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_state == ST_MUL_BAT && r_cnt == MUL_TOP)
        else $error("start did not launch the first multiply");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE |=> r_state == ST_IDLE)
        else $error("done held longer than one cycle");

endmodule

FILE: rtl/battery_voltage_averager_unit.sv
// ----------------------------------------------------------------------------
// battery_voltage_averager_unit
// Averages reference/battery sample pairs and serves millivolt readings.
// ----------------------------------------------------------------------------
// Input stream (s_axis): tuser carries the item kind (tick, sample pair,
// read), tdata the two 12-bit conversions. Only a read produces a
// transaction on the output stream (m_axis): millivolts and a due flag.
// Registers offset, calibration and interval sit on the APB port.
// A tick, a read, or a sample pair that does not complete an average leaves
// the arithmetic unit idle; a read result appears in the output register the
// cycle after acceptance. The pair that completes an average starts the
// bit-serial arithmetic unit: two shift-add multiplies, a restoring divide
// and a finishing state, and no next item is taken until it is done. That
// unit sets the worst-case rate.
// Reset loads the register defaults, clears sums and cache and marks a
// measurement as due. When the receiver stalls, the result waits in the
// output register and the input stream stalls too; the next transaction of
// any kind is taken once the output register is free or being drained.
// ----------------------------------------------------------------------------
module battery_voltage_averager_unit
    import bva_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [23:0]       s_axis_tdata,   // [11:0] vref_sample, [23:12] vbat_sample
    input  logic [1:0]        s_axis_tuser,   // [1:0] mode
    // output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,   // [15:0] battery_mv, [16] measure_due, pad
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam logic [CNT_W-1:0] LAST_PAIR = CNT_W'(AVG_N - 1);

    logic [MV_W-1:0]     r_offset;
    logic [CAL_W-1:0]    r_cal;
    logic [31:0]         r_interval;
    logic [SUM_W-1:0]    r_ref_sum, r_bat_sum;
    logic [CNT_W-1:0]    r_pair_count;
    logic [CACHE_W-1:0]  r_cached;
    logic [31:0]         r_elapsed;
    logic                r_out_valid;
    logic [23:0]         r_out_data;

    t_mode               mode;
    logic                s_acc;
    logic                cfg_wr;
    logic [SUM_W-1:0]    ref_total, bat_total;
    logic                avg_start;
    t_arith_status       arith_st;
    logic [CACHE_W-1:0]  arith_mv;
    logic [MV_W:0]       adj_sum;
    logic [MV_W-1:0]     read_mv;
    logic                due;

    assign mode          = t_mode'(s_axis_tuser);
    assign s_axis_tready = !arith_st.busy && (!r_out_valid || m_axis_tready);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite && pready;

    assign ref_total = r_ref_sum + SUM_W'(s_axis_tdata[SAMPLE_W-1:0]);
    assign bat_total = r_bat_sum + SUM_W'(s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]);
    assign avg_start = s_acc && (mode == MODE_SAMPLE) && (r_pair_count == LAST_PAIR);

    bva_arith u_arith (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (avg_start),
        .i_ref_avg (ref_total[SUM_W-1:AVG_LOG2]),
        .i_bat_avg (bat_total[SUM_W-1:AVG_LOG2]),
        .i_cal     (r_cal),
        .o_status  (arith_st),
        .o_mv      (arith_mv)
    );

    // cached value plus signed offset, saturated to 16 bits; a cache below LOW_LIMIT_MV reads all ones
    assign adj_sum = {2'b00, r_cached} + {r_offset[MV_W-1], r_offset};
    always_comb begin
        if (r_cached < LOW_LIMIT_MV) begin
            read_mv = '1;
        end else if (adj_sum[MV_W] != adj_sum[MV_W-1]) begin
            read_mv = adj_sum[MV_W] ? {1'b1, {(MV_W-1){1'b0}}} : {1'b0, MV_MAX};
        end else begin
            read_mv = adj_sum[MV_W-1:0];
        end
    end
    assign due = (r_elapsed >= r_interval);

    always_comb begin
        case (paddr[3:2])
            REG_OFFSET:   prdata = {{16{r_offset[MV_W-1]}}, r_offset};
            REG_CAL:      prdata = {20'd0, r_cal};
            REG_INTERVAL: prdata = r_interval;
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset     <= OFFSET_RST;
            r_cal        <= CAL_RST;
            r_interval   <= INTERVAL_RST;
            r_ref_sum    <= '0;
            r_bat_sum    <= '0;
            r_pair_count <= '0;
            r_cached     <= '0;
            r_elapsed    <= '1;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_OFFSET:   r_offset   <= pwdata[MV_W-1:0];
                    REG_CAL:      r_cal      <= pwdata[CAL_W-1:0];
                    REG_INTERVAL: r_interval <= pwdata;
                    default:      ;
                endcase
            end

            if (arith_st.done) begin
                r_cached <= arith_mv;
            end

            if (s_acc && mode == MODE_READ) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (s_acc) begin
                case (mode)
                    MODE_TICK: begin
                        if (r_elapsed != '1) begin
                            r_elapsed <= r_elapsed + 32'd1;
                        end
                    end
                    MODE_SAMPLE: begin
                        if (avg_start) begin
                            r_ref_sum    <= '0;
                            r_bat_sum    <= '0;
                            r_pair_count <= '0;
                            r_elapsed    <= '0;
                        end else begin
                            r_ref_sum    <= ref_total;
                            r_bat_sum    <= bat_total;
                            r_pair_count <= r_pair_count + 1'b1;
                        end
                    end
                    MODE_READ: ;
                    default: ;
                endcase
            end
        end
        if (s_acc && mode == MODE_READ) begin
            r_out_data <= {7'd0, due, read_mv};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        arith_st.busy |-> !s_axis_tready)
        else $error("input taken while arithmetic unit busy");

    a_pair_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !arith_st.busy |-> r_pair_count <= LAST_PAIR)
        else $error("pair count beyond averaging depth");

    a_avg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        avg_start |=> arith_st.busy && r_elapsed == '0 && r_pair_count == '0)
        else $error("completed average did not restart measurement");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && mode == MODE_READ) |=> m_axis_tvalid)
        else $error("read transaction produced no result");

endmodule

FILE: dv/tb_battery_voltage_averager_unit.sv
// ----------------------------------------------------------------------------
// tb_battery_voltage_averager_unit
// Self-checking bench for the battery voltage averager. Ticks, sample pairs
// and reads go in on the input stream. A scoreboard model of the sums, cache
// and elapsed counter predicts each reading, which is compared field by field
// with the output stream. Registers are changed between phases over APB,
// and both stream sides idle at varying rates.
// ----------------------------------------------------------------------------
module tb_battery_voltage_averager_unit;
    import bva_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         SETTLE_CYCLES = 80;   // covers a full arithmetic pass
    localparam int         PHASE_ITEMS   = 210;

    typedef struct {
        logic [15:0] mv;
        logic        due;
    } t_reading;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [23:0]       s_axis_tdata;
    logic [1:0]        s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [23:0]       m_axis_tdata;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    battery_voltage_averager_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // model state and register copies
    logic [31:0]        ref_acc;
    logic [31:0]        bat_acc;
    int unsigned        pairs_taken;
    int unsigned        cache_mv;
    logic [31:0]        ticks_since;
    logic signed [15:0] cfg_offset;
    logic [11:0]        cfg_cal;
    logic [31:0]        cfg_interval;

    t_reading pending_readings[$];

    int mismatches;
    int items_sent;
    int readings_checked;
    int averages_done;
    int send_idle_pct;
    int recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // scoreboard model
    // ------------------------------------------------------------------------
    task automatic reset_model();
        ref_acc      = '0;
        bat_acc      = '0;
        pairs_taken  = 0;
        cache_mv     = 0;
        ticks_since  = '1;
        cfg_offset   = OFFSET_RST;
        cfg_cal      = CAL_RST;
        cfg_interval = INTERVAL_RST;
    endtask

    task automatic predict_item(input logic [1:0] mode, input logic [23:0] data);
        logic [31:0] vref_avg;
        logic [31:0] vbat_avg;
        logic [31:0] scaled;
        logic [31:0] quot;
        int          mv;
        t_reading    rd;
        case (mode)
            MODE_TICK: begin
                if (ticks_since != '1) ticks_since = ticks_since + 1;
            end
            MODE_SAMPLE: begin
                ref_acc = ref_acc + data[11:0];
                bat_acc = bat_acc + data[23:12];
                pairs_taken++;
                if (pairs_taken >= AVG_N) begin
                    vref_avg = ref_acc >> AVG_LOG2;
                    vbat_avg = bat_acc >> AVG_LOG2;
                    scaled   = ((32'd6600 * vbat_avg) >> 12) * cfg_cal;
                    if (vref_avg == 0) begin
                        quot = 32'd32767;
                    end else begin
                        quot = scaled / vref_avg;
                        if (quot > 32'd32767) quot = 32'd32767;
                    end
                    cache_mv    = quot;
                    ref_acc     = '0;
                    bat_acc     = '0;
                    pairs_taken = 0;
                    ticks_since = '0;
                    averages_done++;
                end
            end
            MODE_READ: begin
                if (cache_mv < 100) begin
                    mv = -1;
                end else begin
                    mv = int'(cache_mv) + int'(cfg_offset);
                    if (mv > 32767) mv = 32767;
                    if (mv < -32768) mv = -32768;
                end
                rd.mv  = mv[15:0];
                rd.due = (ticks_since >= cfg_interval);
                pending_readings.push_back(rd);
            end
            default: ;   // unused mode, no effect
        endcase
    endtask

    task automatic check_reading(input logic [15:0] mv, input logic due);
        t_reading rd;
        readings_checked++;
        if (pending_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] unexpected reading: mv %0d due %0b", $realtime,
                         $signed(mv), due);
        end else begin
            rd = pending_readings.pop_front();
            if (rd.mv !== mv || rd.due !== due) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] reading mismatch: mv exp %0d got %0d, due exp %0b got %0b",
                             $realtime, $signed(rd.mv), $signed(mv), rd.due, due);
            end
        end
    endtask

    // both streams sampled at the edge, before any update lands
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) predict_item(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                check_reading(m_axis_tdata[15:0], m_axis_tdata[16]);
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [1:0] mode, input logic [23:0] data);
        // one draw per cycle, each idling the sender with a chance of send_idle_pct percent
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (mode != MODE_UNUSED) items_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_OFFSET:   cfg_offset   = val[15:0];
            REG_CAL:      cfg_cal      = val[11:0];
            REG_INTERVAL: cfg_interval = val;
            default: ;
        endcase
    endtask

    // {vbat, vref} drawn from a value class: uniform by default, else aimed at one corner of the math
    function automatic logic [23:0] pick_pair(input int cls);
        logic [11:0] vr;
        logic [11:0] vb;
        case (cls)
            1: begin
                vr = '0;
                vb = 12'($urandom_range(0, 4095));
            end
            2: begin
                vr = 12'($urandom_range(1, 3));
                vb = 12'($urandom_range(2048, 4095));
            end
            3: begin
                vr = 12'($urandom_range(1200, 4095));
                vb = 12'($urandom_range(0, 60));
            end
            4: begin
                vr = 12'($urandom_range(1400, 1600));
                vb = 12'($urandom_range(1500, 2600));
            end
            5: begin
                vr = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                vb = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            end
            default: begin
                vr = 12'($urandom_range(0, 4095));
                vb = 12'($urandom_range(0, 4095));
            end
        endcase
        return {vb, vr};
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_reset_defaults();
        send_item(MODE_READ, '0);           // empty cache reads -1, due after reset
        send_item(MODE_TICK, '0);           // counter stays saturated
        send_item(MODE_TICK, '1);
        send_item(MODE_READ, '1);
        send_item(MODE_UNUSED, '1);         // ignored
        send_item(MODE_READ, '0);
    endtask

    task automatic test_zero_reference();
        for (int i = 0; i < AVG_N; i++) send_item(MODE_SAMPLE, {12'hFFF, 12'h000});
        send_item(MODE_READ, '0);
        send_item(MODE_TICK, '0);
        send_item(MODE_READ, '0);
    endtask

    task automatic run_random_items(input int target);
        int first;
        int kind;
        int cls;
        int n;
        first = items_sent;
        while (items_sent - first < target) begin
            kind = $urandom_range(0, 9);
            if (kind <= 4) begin
                // full measurement with stray ticks and reads mixed in
                cls = $urandom_range(0, 5);
                for (int i = 0; i < AVG_N; i++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_item(($urandom_range(0, 1) != 0) ? MODE_TICK : MODE_READ,
                                  24'($urandom));
                    send_item(MODE_SAMPLE, pick_pair(cls));
                end
                send_item(MODE_READ, 24'($urandom));
            end else if (kind <= 7) begin
                // walk the elapsed counter across the interval
                n = $urandom_range(0, 40);
                for (int i = 0; i < n; i++) begin
                    send_item(MODE_TICK, 24'($urandom));
                    if ($urandom_range(0, 7) == 0) send_item(MODE_READ, 24'($urandom));
                end
                send_item(MODE_READ, 24'($urandom));
            end else if (kind == 8) begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    send_item(2'($urandom_range(0, 3)), 24'($urandom));
            end else begin
                // broken measurement: partial set carried into the next one
                n = $urandom_range(1, AVG_N - 1);
                for (int i = 0; i < n; i++) send_item(MODE_SAMPLE, pick_pair(0));
                send_item(MODE_READ, 24'($urandom));
            end
        end
    endtask

    task automatic test_config_phases();
        logic [31:0] off;
        logic [31:0] cal;
        logic [31:0] intv;
        for (int phase = 0; phase < 8; phase++) begin
            wait_idle();
            case (phase)
                0: begin off = 32'h0000;     cal = 32'd1530; intv = 32'd0;         end
                1: begin off = 32'h7FFF;     cal = 32'd4095; intv = 32'd1;         end
                2: begin off = 32'hFFFF8000; cal = 32'd0;    intv = 32'hFFFF_FFFF; end
                3: begin off = 32'hFFFFFF9C; cal = 32'd1530; intv = 32'd20;        end
                default: begin
                    off  = $urandom;
                    cal  = ($urandom_range(0, 1) != 0) ? $urandom_range(1400, 1700)
                                                       : $urandom_range(0, 4095);
                    intv = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 40) : $urandom;
                end
            endcase
            write_reg(REG_OFFSET, off);
            write_reg(REG_CAL, cal);
            write_reg(REG_INTERVAL, intv);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            run_random_items(PHASE_ITEMS);
        end
    endtask

    initial begin
        mismatches       = 0;
        items_sent       = 0;
        readings_checked = 0;
        averages_done    = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        reset_model();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= MODE_TICK;
        m_axis_tready <= 1'b1;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_zero_reference();
        test_config_phases();
        wait_idle();

        $display("covered %0d items, %0d readings checked, %0d averages completed",
                 items_sent, readings_checked, averages_done);
        $display("register extremes and four stream idling patterns over 8 phases");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches in total", mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/bva_pkg.sv
rtl/bva_arith.sv
rtl/battery_voltage_averager_unit.sv
dv/tb_battery_voltage_averager_unit.sv
